// ===== rtl/core/r2p_pkg.sv =====
// ----------------------------------------------------------------------------
// r2p_pkg
// Shared constants for the rectangular to polar converter: widths, angle
// scaling and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package r2p_pkg;

  localparam int DATA_WIDTH_DEF = 16;

  // CORDIC datapath
  localparam int CORDIC_STEPS   = 24;
  localparam int PRESHIFT_BASE  = 60;   // operands are shifted so their top bit lands at bit 59
  localparam int XY_W           = 62;   // holds 2^59 * sqrt(2) * gain, signed
  localparam int ANG_W          = 32;   // 2^32 units per full turn
  localparam int ROUND_SHIFT    = 17;   // accumulator units to output units
  localparam int ROUND_HALF     = 65536;

  // Phase output
  localparam int PH_W           = 16;
  localparam int TH_W           = 14;   // first-quadrant angle, 0..8192
  localparam int HALF_TURN      = 16384;
  localparam int QUARTER_TURN   = 8192;

  localparam logic signed [ANG_W-1:0] ARC_TABLE [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

// ===== rtl/core/r2p_cordic.sv =====
// ----------------------------------------------------------------------------
// r2p_cordic
// Pipelined vectoring CORDIC on |re|, |im|: one rotation per stage, then a
// rounding stage giving the first-quadrant angle in units of pi/16384.
// ----------------------------------------------------------------------------
module r2p_cordic #(
  parameter int DATA_WIDTH = r2p_pkg::DATA_WIDTH_DEF,
  parameter int LAT        = r2p_pkg::CORDIC_STEPS + 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [DATA_WIDTH-1:0]       a,
  input  logic [DATA_WIDTH-1:0]       b,
  output logic [r2p_pkg::TH_W-1:0]    theta
);
  import r2p_pkg::*;

  localparam int OWN_LAT = CORDIC_STEPS + 1;
  localparam int PAD     = LAT - OWN_LAT;

  logic signed [XY_W-1:0]  x_r [CORDIC_STEPS];
  logic signed [XY_W-1:0]  y_r [CORDIC_STEPS];
  logic signed [ANG_W-1:0] z_r [CORDIC_STEPS];
  logic signed [XY_W-1:0]  x_in;
  logic signed [XY_W-1:0]  y_in;
  logic [TH_W-1:0]         th_nxt;
  logic [TH_W-1:0]         th_r;
  logic signed [ANG_W-1:0] z_rnd;
  logic [ANG_W-ROUND_SHIFT-1:0] p_raw;

  assign x_in = $signed({{(XY_W-DATA_WIDTH){1'b0}}, a} << (PRESHIFT_BASE - DATA_WIDTH));
  assign y_in = $signed({{(XY_W-DATA_WIDTH){1'b0}}, b} << (PRESHIFT_BASE - DATA_WIDTH));

  genvar i;
  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [XY_W-1:0]  xp, yp, x_nxt, y_nxt;
      logic signed [ANG_W-1:0] zp, z_nxt;

      if (i == 0) begin : g_first
        assign xp = x_in;
        assign yp = y_in;
        assign zp = '0;
      end else begin : g_next
        assign xp = x_r[i-1];
        assign yp = y_r[i-1];
        assign zp = z_r[i-1];
      end

      // rotate towards the x axis
      always_comb begin
        if (!yp[XY_W-1]) begin
          x_nxt = xp + (yp >>> i);
          y_nxt = yp - (xp >>> i);
          z_nxt = zp + ARC_TABLE[i];
        end else begin
          x_nxt = xp - (yp >>> i);
          y_nxt = yp + (xp >>> i);
          z_nxt = zp - ARC_TABLE[i];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          x_r[i] <= x_nxt;
          y_r[i] <= y_nxt;
          z_r[i] <= z_nxt;
        end
      end
    end
  endgenerate

  // round to pi/16384, clamp to 0..a quarter turn
  assign z_rnd = z_r[CORDIC_STEPS-1] + ANG_W'(ROUND_HALF);
  assign p_raw = z_rnd[ANG_W-1:ROUND_SHIFT];

  always_comb begin
    if (z_r[CORDIC_STEPS-1][ANG_W-1]) begin
      th_nxt = '0;
    end else if (p_raw > (ANG_W-ROUND_SHIFT)'(QUARTER_TURN)) begin
      th_nxt = TH_W'(QUARTER_TURN);
    end else begin
      th_nxt = p_raw[TH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th_r <= th_nxt;
    end
  end

  // align with the root pipeline
  generate
    if (PAD > 0) begin : g_pad
      logic [TH_W-1:0] pad_r [PAD];
      always_ff @(posedge clk) begin
        if (en) begin
          pad_r[0] <= th_r;
          for (int k = 1; k < PAD; k++) begin
            pad_r[k] <= pad_r[k-1];
          end
        end
      end
      assign theta = pad_r[PAD-1];
    end else begin : g_nopad
      assign theta = th_r;
    end
  endgenerate

endmodule

// ===== rtl/core/r2p_root.sv =====
// ----------------------------------------------------------------------------
// r2p_root
// Pipelined magnitude: squares, sum, one root bit per stage, then rounding
// to nearest from the final remainder.
// ----------------------------------------------------------------------------
module r2p_root #(
  parameter int DATA_WIDTH = r2p_pkg::DATA_WIDTH_DEF,
  parameter int LAT        = DATA_WIDTH + 3
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic [DATA_WIDTH-1:0] mag
);
  import r2p_pkg::*;

  localparam int DW      = DATA_WIDTH;
  localparam int SW      = 2 * DW;
  localparam int RW      = DW + 2;
  localparam int OWN_LAT = DW + 3;
  localparam int PAD     = LAT - OWN_LAT;

  logic [SW-1:0] asq_r, bsq_r, sum_r;
  logic [SW-1:0] s_r    [DW];
  logic [RW-1:0] rem_r  [DW];
  logic [DW-1:0] root_r [DW];
  logic [DW-1:0] mag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      asq_r <= SW'(a) * SW'(a);
      bsq_r <= SW'(b) * SW'(b);
      sum_r <= asq_r + bsq_r;
    end
  end

  genvar j;
  generate
    for (j = 0; j < DW; j++) begin : g_bit
      localparam int K = DW - 1 - j;   // bit pair handled here
      logic [SW-1:0]   sp;
      logic [RW-1:0]   remp;
      logic [DW-1:0]   rootp;
      logic [RW+1:0]   cur;
      logic [RW+1:0]   trial;
      logic [RW-1:0]   rem_nxt;
      logic [DW-1:0]   root_nxt;

      if (j == 0) begin : g_first
        assign sp    = sum_r;
        assign remp  = '0;
        assign rootp = '0;
      end else begin : g_next
        assign sp    = s_r[j-1];
        assign remp  = rem_r[j-1];
        assign rootp = root_r[j-1];
      end

      assign cur   = {remp, sp[2*K+1 -: 2]};
      assign trial = (RW+2)'({rootp, 2'b01});

      always_comb begin
        if (cur >= trial) begin
          rem_nxt  = RW'(cur - trial);
          root_nxt = {rootp[DW-2:0], 1'b1};
        end else begin
          rem_nxt  = RW'(cur);
          root_nxt = {rootp[DW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          s_r[j]    <= sp;
          rem_r[j]  <= rem_nxt;
          root_r[j] <= root_nxt;
        end
      end
    end
  endgenerate

  // remainder above the root means the upper neighbour is nearer
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_r[DW-1] > RW'(root_r[DW-1])) begin
        mag_r <= root_r[DW-1] + DW'(1);
      end else begin
        mag_r <= root_r[DW-1];
      end
    end
  end

  generate
    if (PAD > 0) begin : g_pad
      logic [DW-1:0] pad_r [PAD];
      always_ff @(posedge clk) begin
        if (en) begin
          pad_r[0] <= mag_r;
          for (int k = 1; k < PAD; k++) begin
            pad_r[k] <= pad_r[k-1];
          end
        end
      end
      assign mag = pad_r[PAD-1];
    end else begin : g_nopad
      assign mag = mag_r;
    end
  endgenerate

endmodule

// ===== rtl/core/rect_to_polar_converter_unit.sv =====
// ----------------------------------------------------------------------------
// rect_to_polar_converter_unit
// Complex sample to magnitude and four-quadrant phase, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one complex sample per item; in_tdata = {imag_part, real_part},
//           in_tlast carries the end-of-block flag.
//   out_* : one result per item; out_tdata = {phase, magnitude}, out_tlast
//           is the flag of the matching sample. Results keep input order.
//   Phase is in units of pi/16384 (-16384..16384), magnitude is rounded.
//   Throughput: one item per cycle, no gaps between items, while the output is not held.
//   Latency from acceptance to out_tvalid is set by the longer core: the
//   24 CORDIC rotation stages plus rounding, or the squaring, sum,
//   DATA_WIDTH root-bit and rounding stages when those are longer.
//   Reset clears all valid bits; the pipeline comes out empty.
//   When out_tready is low with a result waiting, the whole pipeline holds
//   and one further item is taken into an input holding register; in_tready
//   then drops until the pipeline moves again.
// ----------------------------------------------------------------------------
module rect_to_polar_converter_unit #(
  parameter  int DATA_WIDTH  = r2p_pkg::DATA_WIDTH_DEF,
  localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((DATA_WIDTH + r2p_pkg::PH_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // real_part, imag_part
  input  logic                   in_tlast,   // end_of_block
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // magnitude, phase
  output logic                   out_tlast   // end_of_block_out
);
  import r2p_pkg::*;

  localparam int DW       = DATA_WIDTH;
  localparam int CORE_LAT = (CORDIC_STEPS + 1 > DW + 3) ? CORDIC_STEPS + 1 : DW + 3;

  typedef struct packed {
    logic valid;
    logic re_neg;
    logic im_neg;
    logic a_zero;
    logic b_zero;
    logic last;
  } side_t;

  logic                 en;
  logic                 in_fire;
  logic                 skid_valid_r;
  logic [DW-1:0]        skid_re_r, skid_im_r;
  logic                 skid_last_r;
  logic [DW-1:0]        src_re, src_im;
  logic                 src_last;
  logic [DW-1:0]        a_r, b_r;
  side_t                side_r [CORE_LAT+1];
  side_t                side_nxt;
  logic [TH_W-1:0]      theta;
  logic [DW-1:0]        mag;
  logic [TH_W-1:0]      th_sel;
  logic signed [PH_W-1:0] ph_nxt;
  logic signed [PH_W-1:0] phase_r;
  logic [DW-1:0]        mag_r;
  logic                 last_r;
  logic                 out_valid_r;

  assign en        = out_tready | ~out_valid_r;
  assign in_tready = ~skid_valid_r;
  assign in_fire   = in_tvalid & in_tready;

  // input holding register, filled only while the pipeline is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else if (en) begin
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_fire) begin
      skid_re_r   <= in_tdata[DW-1:0];
      skid_im_r   <= in_tdata[2*DW-1:DW];
      skid_last_r <= in_tlast;
    end
  end

  assign src_re   = skid_valid_r ? skid_re_r   : in_tdata[DW-1:0];
  assign src_im   = skid_valid_r ? skid_im_r   : in_tdata[2*DW-1:DW];
  assign src_last = skid_valid_r ? skid_last_r : in_tlast;

  always_comb begin
    side_nxt.valid  = skid_valid_r | in_fire;
    side_nxt.re_neg = src_re[DW-1];
    side_nxt.im_neg = src_im[DW-1];
    side_nxt.a_zero = (src_re == '0);
    side_nxt.b_zero = (src_im == '0);
    side_nxt.last   = src_last;
  end

  // absolute values; the most negative code maps to 2^(DW-1), still DW bits
  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= src_re[DW-1] ? DW'(~src_re + DW'(1)) : src_re;
      b_r <= src_im[DW-1] ? DW'(~src_im + DW'(1)) : src_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= CORE_LAT; k++) begin
        side_r[k] <= '0;
      end
    end else if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k <= CORE_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  r2p_cordic #(
    .DATA_WIDTH (DW),
    .LAT        (CORE_LAT)
  ) u_cordic (
    .clk   (clk),
    .en    (en),
    .a     (a_r),
    .b     (b_r),
    .theta (theta)
  );

  r2p_root #(
    .DATA_WIDTH (DW),
    .LAT        (CORE_LAT)
  ) u_root (
    .clk (clk),
    .en  (en),
    .a   (a_r),
    .b   (b_r),
    .mag (mag)
  );

  // axis cases, then quadrant mapping
  always_comb begin
    if (side_r[CORE_LAT].b_zero) begin
      th_sel = '0;
    end else if (side_r[CORE_LAT].a_zero) begin
      th_sel = TH_W'(QUARTER_TURN);
    end else begin
      th_sel = theta;
    end

    if (side_r[CORE_LAT].re_neg) begin
      ph_nxt = PH_W'(HALF_TURN) - PH_W'(th_sel);
    end else begin
      ph_nxt = PH_W'(th_sel);
    end
    if (side_r[CORE_LAT].im_neg) begin
      ph_nxt = -ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_r[CORE_LAT].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= mag;
      phase_r <= ph_nxt;
      last_r  <= side_r[CORE_LAT].last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({phase_r, mag_r});
  assign out_tlast  = last_r;

`ifndef SYNTHESIS
  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !en) |=> skid_valid_r)
    else $error("item taken during a hold was not kept in the holding register");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (phase_r <= PH_W'(HALF_TURN)) && (phase_r >= -PH_W'(HALF_TURN)))
    else $error("phase outside -pi..+pi");

  a_zero_mag_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (mag_r == '0)) |-> (phase_r == '0))
    else $error("zero magnitude with non-zero phase");

  a_hold_keeps_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !en) |=> skid_valid_r)
    else $error("held item lost while pipeline stalled");
`endif

endmodule
